[design/mau_pkg.sv]
// ----------------------------------------------------------------------------
// mau_pkg
// shared types and constants of the modular arithmetic unit
// ----------------------------------------------------------------------------
package mau_pkg;

    localparam int RB = 31;                       // residue width
    localparam int RAW_BITS = 64;
    localparam int EXP_BITS = 63;
    localparam int OP_BITS = 4;
    localparam int DIV_CNT_BITS = $clog2(RAW_BITS + 1);
    localparam logic [RB-1:0] MODULUS_RESET = RB'(1000000007);

    typedef logic [RB-1:0] res_t;

    typedef enum logic [OP_BITS-1:0] {
        OP_REDUCE = 4'd0,
        OP_ADD    = 4'd1,
        OP_SUB    = 4'd2,
        OP_MUL    = 4'd3,
        OP_DIV    = 4'd4,
        OP_POW    = 4'd5,
        OP_INC    = 4'd6,
        OP_DEC    = 4'd7,
        OP_EQ     = 4'd8
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_A,      // a mod m
        ST_RED_B,      // b mod m
        ST_RED_RAW,    // |raw| mod m
        ST_SIMPLE,     // add, sub, inc, dec and eq ops
        ST_PW_TEST,    // check exponent bit / done
        ST_PW_MUL,     // result *= base
        ST_PW_SQR,     // base *= base
        ST_FIN_MUL,    // final a * x
        ST_OUT
    } state_t;

    // datapath commands
    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_START_RED_A,
        DP_START_RED_B,
        DP_START_RED_RAW,
        DP_SIMPLE,
        DP_PW_INIT,
        DP_START_PW_MUL,
        DP_START_PW_SQR,
        DP_PW_SHIFT,
        DP_START_FIN,
        DP_FIN_RAW,
        DP_FIN_PW,
        DP_FIN_MUL,
        DP_SMALL_MOD
    } dp_cmd_t;

    // destination of the iterative unit result
    typedef enum logic [1:0] {D_A, D_B, D_RES, D_BASE} dst_t;

    typedef struct packed {
        logic    busy;      // iterative unit running
        logic    exp_zero;
        logic    exp_lsb;
        logic    small_mod; // modulus below two
        op_t     op;
    } dp_status_t;

endpackage

[design/modular_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// residue arithmetic modulo a configurable modulus, fermat-inverse division
// ----------------------------------------------------------------------------
// channel  dir  handshake                 payload
// s_       in   s_tvalid / s_tready       tdata: operand_a,operand_b,raw_value,
//                                          exponent; tuser: req_type
// m_       out  m_tvalid / m_tready       tdata: residue,is_equal
// cfg_     in   cfg_valid / cfg_ready     cfg_data: modulus
//
// one item at a time: the operands are reduced on the shared remainder unit,
// and each modular multiply runs in the shared shift-add unit; pow takes up
// to about 126 multiplies, div up to about 63 multiplies
// reset sets the modulus to 1000000007 and returns the sequencer to idle
// the result is held in its register until taken, s_tready is low meanwhile
module modular_arithmetic_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // operand_a[30:0], operand_b[61:31],
                                    // raw_value[125:62], exponent[188:126]
    input  logic [3:0]   s_tuser,   // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // residue[30:0], is_equal[31]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [30:0]  cfg_data   // modulus
);
    import mau_pkg::*;

    res_t              modulus_reg;
    dp_cmd_t           cmd;
    dp_status_t        status;
    logic              in_fire, out_fire;
    res_t              residue;
    logic              is_equal;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = m_tvalid && m_tready;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= MODULUS_RESET;
        end else if (cfg_valid) begin
            modulus_reg <= cfg_data;
        end
    end

    mau_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .out_fire (out_fire),
        .status   (status),
        .cmd      (cmd),
        .s_ready  (s_tready),
        .m_valid  (m_tvalid)
    );

    mau_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .modulus   (modulus_reg),
        .req_type  (s_tuser),
        .operand_a (s_tdata[30:0]),
        .operand_b (s_tdata[61:31]),
        .raw_value (s_tdata[125:62]),
        .exponent  (s_tdata[188:126]),
        .status    (status),
        .residue   (residue),
        .is_equal  (is_equal)
    );

    assign m_tdata = {is_equal, residue};

    a_cfg_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("accepting while result pending");
endmodule

[design/mau_ctrl.sv]
// ----------------------------------------------------------------------------
// mau_ctrl
// sequencer: steps one item through reduce, power and multiply phases
// ----------------------------------------------------------------------------
module mau_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic                 out_fire,
    input  mau_pkg::dp_status_t  status,
    output mau_pkg::dp_cmd_t     cmd,
    output logic                 s_ready,
    output logic                 m_valid
);
    import mau_pkg::*;

    state_t state_reg, state_next;
    logic   is_pow;

    assign is_pow = (status.op == OP_POW) || (status.op == OP_DIV);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_fire) state_next = ST_RED_A;
            ST_RED_A: begin
                if (status.small_mod) state_next = ST_OUT;
                else if (!status.busy) state_next = ST_RED_B;
            end
            ST_RED_B: begin
                if (!status.busy) begin
                    if (status.op == OP_REDUCE) state_next = ST_RED_RAW;
                    else if (is_pow) state_next = ST_PW_TEST;
                    else if (status.op == OP_MUL) state_next = ST_FIN_MUL;
                    else state_next = ST_SIMPLE;
                end
            end
            ST_RED_RAW: if (!status.busy) state_next = ST_OUT;
            ST_SIMPLE:  state_next = ST_OUT;
            ST_PW_TEST: begin
                if (status.exp_zero)
                    state_next = (status.op == OP_DIV) ? ST_FIN_MUL : ST_OUT;
                else if (status.exp_lsb) state_next = ST_PW_MUL;
                else state_next = ST_PW_SQR;
            end
            ST_PW_MUL:  if (!status.busy) state_next = ST_PW_SQR;
            ST_PW_SQR:  if (!status.busy) state_next = ST_PW_TEST;
            ST_FIN_MUL: if (!status.busy) state_next = ST_OUT;
            ST_OUT:     if (out_fire) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // commands fire on the input handshake, in the test and simple states, on a small modulus, or on completion
    always_comb begin
        cmd = DP_NONE;
        unique case (state_reg)
            ST_IDLE:    if (in_fire) cmd = DP_LOAD;
            ST_RED_A: begin
                if (status.small_mod) cmd = DP_SMALL_MOD;
                else if (!status.busy) cmd = DP_START_RED_B;
            end
            ST_RED_B: begin
                if (!status.busy) begin
                    if (status.op == OP_REDUCE) cmd = DP_START_RED_RAW;
                    else if (is_pow) cmd = DP_PW_INIT;
                    else if (status.op == OP_MUL) cmd = DP_START_FIN;
                end
            end
            ST_RED_RAW: if (!status.busy) cmd = DP_FIN_RAW;
            ST_SIMPLE:  cmd = DP_SIMPLE;
            ST_PW_TEST: begin
                if (status.exp_zero)
                    cmd = (status.op == OP_DIV) ? DP_START_FIN : DP_FIN_PW;
                else if (status.exp_lsb) cmd = DP_START_PW_MUL;
                else cmd = DP_START_PW_SQR;
            end
            ST_PW_MUL:  if (!status.busy) cmd = DP_START_PW_SQR;
            ST_PW_SQR:  if (!status.busy) cmd = DP_PW_SHIFT;
            ST_FIN_MUL: if (!status.busy) cmd = DP_FIN_MUL;
            default:    cmd = DP_NONE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !out_fire) |=> m_valid)
        else $error("result dropped while stalled");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output open together");
    a_load_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == DP_LOAD) |-> s_ready)
        else $error("load outside idle");
endmodule

[design/mau_dpath.sv]
// ----------------------------------------------------------------------------
// mau_dpath
// operand registers, restoring remainder unit and shift-add multiplier
// ----------------------------------------------------------------------------
module mau_dpath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mau_pkg::dp_cmd_t            cmd,
    input  logic [mau_pkg::RB-1:0]      modulus,
    input  logic [mau_pkg::OP_BITS-1:0] req_type,
    input  logic [mau_pkg::RB-1:0]      operand_a,
    input  logic [mau_pkg::RB-1:0]      operand_b,
    input  logic [mau_pkg::RAW_BITS-1:0] raw_value,
    input  logic [mau_pkg::EXP_BITS-1:0] exponent,
    output mau_pkg::dp_status_t         status,
    output logic [mau_pkg::RB-1:0]      residue,
    output logic                        is_equal
);
    import mau_pkg::*;

    typedef enum logic [1:0] {U_IDLE, U_DIV, U_MUL} unit_t;

    logic [OP_BITS-1:0]  op_reg;
    res_t                m_reg, a_reg, b_reg, oa_reg, ob_reg, res_reg, base_reg;
    logic [RAW_BITS-1:0] raw_reg;
    logic                neg_reg, eq_reg;
    logic [EXP_BITS-1:0] exp_reg;

    // shared iterative unit
    unit_t               unit_reg;
    logic [RAW_BITS-1:0] dq_reg;       // dividend shifted out msb first
    logic [RB:0]         acc_reg;      // running remainder / product
    res_t                mx_reg, my_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    dst_t                dst_reg;
    logic [RB+1:0]       dbl, dsum;
    logic [RB:0]         dbl_r;
    logic [RB:0]         trial;
    logic                done;
    res_t                fin;
    logic [RB:0]         add_sum;
    res_t                simple_res;

    // one step of remainder: acc = (acc*2 + bit) mod m
    assign trial = {acc_reg[RB-1:0], dq_reg[RAW_BITS-1]};
    // one step of multiply: acc = 2acc (+x) mod m
    assign dbl   = {1'b0, acc_reg} + {1'b0, acc_reg};
    assign dbl_r = (dbl >= {2'b0, m_reg}) ? (RB+1)'(dbl - {2'b0, m_reg}) : dbl[RB:0];
    assign dsum  = {1'b0, dbl_r} + (my_reg[RB-1] ? {2'b0, mx_reg} : '0);

    // commands start the unit (a small modulus stops it), otherwise it steps until the count runs out
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_reg <= U_IDLE;
        end else begin
            unique case (cmd)
                DP_LOAD: begin
                    unit_reg <= U_DIV;
                    acc_reg  <= '0;
                    dq_reg   <= {operand_a, {(RAW_BITS-RB){1'b0}}};
                    cnt_reg  <= DIV_CNT_BITS'(RB);
                    dst_reg  <= D_A;
                end
                DP_START_RED_B: begin
                    unit_reg <= U_DIV;
                    acc_reg  <= '0;
                    dq_reg   <= {ob_reg, {(RAW_BITS-RB){1'b0}}};
                    cnt_reg  <= DIV_CNT_BITS'(RB);
                    dst_reg  <= D_B;
                end
                DP_START_RED_RAW: begin
                    unit_reg <= U_DIV;
                    acc_reg  <= '0;
                    dq_reg   <= neg_reg ? (~raw_reg + 1'b1) : raw_reg;
                    cnt_reg  <= DIV_CNT_BITS'(RAW_BITS);
                    dst_reg  <= D_RES;
                end
                DP_START_PW_MUL: begin
                    unit_reg <= U_MUL;
                    acc_reg <= '0; mx_reg <= res_reg; my_reg <= base_reg;
                    cnt_reg <= DIV_CNT_BITS'(RB); dst_reg <= D_RES;
                end
                DP_START_PW_SQR: begin
                    unit_reg <= U_MUL;
                    acc_reg <= '0; mx_reg <= base_reg; my_reg <= base_reg;
                    cnt_reg <= DIV_CNT_BITS'(RB); dst_reg <= D_BASE;
                end
                DP_START_FIN: begin
                    unit_reg <= U_MUL;
                    acc_reg <= '0; mx_reg <= a_reg;
                    my_reg  <= (op_reg == OP_DIV) ? res_reg : b_reg;
                    cnt_reg <= DIV_CNT_BITS'(RB); dst_reg <= D_RES;
                end
                // nothing to reduce, stop the operand reduction
                DP_SMALL_MOD: unit_reg <= U_IDLE;
                default: begin
                    unique case (unit_reg)
                        U_DIV: begin
                            acc_reg <= (trial >= {1'b0, m_reg}) ? trial - {1'b0, m_reg}
                                                                : trial;
                            dq_reg  <= {dq_reg[RAW_BITS-2:0], 1'b0};
                            cnt_reg <= cnt_reg - 1'b1;
                            if (cnt_reg == DIV_CNT_BITS'(1)) unit_reg <= U_IDLE;
                        end
                        U_MUL: begin
                            acc_reg <= (dsum >= {2'b0, m_reg})
                                ? (RB+1)'(dsum - {2'b0, m_reg}) : dsum[RB:0];
                            my_reg  <= {my_reg[RB-2:0], 1'b0};
                            cnt_reg <= cnt_reg - 1'b1;
                            if (cnt_reg == DIV_CNT_BITS'(1)) unit_reg <= U_IDLE;
                        end
                        default: ;
                    endcase
                end
            endcase
        end
    end

    // completion writes the unit result to its destination
    assign done = (unit_reg != U_IDLE) && (cnt_reg == DIV_CNT_BITS'(1));
    assign fin = (unit_reg == U_DIV)
        ? ((trial >= {1'b0, m_reg}) ? RB'(trial - {1'b0, m_reg}) : trial[RB-1:0])
        : ((dsum >= {2'b0, m_reg}) ? RB'(dsum - {2'b0, m_reg}) : dsum[RB-1:0]);

    // combinational operations on the reduced operands
    assign add_sum = {1'b0, a_reg} + {1'b0, b_reg};

    always_comb begin
        simple_res = '0;
        case (op_reg)
            OP_ADD: simple_res = (add_sum >= {1'b0, m_reg})
                ? RB'(add_sum - {1'b0, m_reg}) : add_sum[RB-1:0];
            OP_SUB: simple_res = (a_reg >= b_reg) ? a_reg - b_reg
                                                  : a_reg + (m_reg - b_reg);
            OP_INC: simple_res = ((a_reg + 1'b1) == m_reg) ? '0 : a_reg + 1'b1;
            OP_DEC: simple_res = (a_reg == '0) ? m_reg - 1'b1 : a_reg - 1'b1;
            default: simple_res = '0;
        endcase
    end

    // the unit never completes in a cycle that carries a command
    always_ff @(posedge aclk) begin
        if (done) begin
            unique case (dst_reg)
                D_A:    a_reg    <= fin;
                D_B:    b_reg    <= fin;
                D_RES:  res_reg  <= fin;
                default: base_reg <= fin;
            endcase
        end else begin
            unique case (cmd)
                DP_LOAD: begin
                    op_reg  <= req_type;
                    m_reg   <= modulus;
                    oa_reg  <= operand_a;
                    ob_reg  <= operand_b;
                    raw_reg <= raw_value;
                    neg_reg <= raw_value[RAW_BITS-1];
                    exp_reg <= exponent;
                    eq_reg  <= 1'b0;
                end
                DP_FIN_RAW: begin
                    if (neg_reg && res_reg != '0) res_reg <= m_reg - res_reg;
                end
                DP_SIMPLE: begin
                    res_reg <= simple_res;
                    eq_reg  <= (op_reg == OP_EQ) && (a_reg == b_reg);
                end
                DP_PW_INIT: begin
                    res_reg  <= RB'(1);
                    if (op_reg == OP_DIV) begin
                        base_reg <= b_reg;
                        exp_reg  <= EXP_BITS'(m_reg - RB'(2));
                    end else begin
                        base_reg <= a_reg;
                    end
                end
                DP_PW_SHIFT: exp_reg <= exp_reg >> 1;
                DP_SMALL_MOD: begin
                    res_reg <= '0;
                    eq_reg  <= (op_reg == OP_EQ) && (oa_reg == ob_reg);
                end
                default: ;
            endcase
        end
    end

    assign status.busy      = (unit_reg != U_IDLE);
    assign status.exp_zero  = (exp_reg == '0);
    assign status.exp_lsb   = exp_reg[0];
    assign status.small_mod = (m_reg < RB'(2));
    assign status.op        = op_t'(op_reg);

    assign residue  = (op_reg > OP_EQ) ? '0 : res_reg;
    assign is_equal = eq_reg;

    a_small_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == DP_SMALL_MOD) |=> (res_reg == '0))
        else $error("small modulus gave nonzero residue");
    a_res_below: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == DP_FIN_MUL && m_reg >= RB'(2)) |-> (res_reg < m_reg))
        else $error("residue not reduced");
    a_unit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == DP_START_PW_MUL) |-> !status.busy)
        else $error("multiply started while unit busy");
endmodule
